// ----- rtl/touch_adc_read_sequencer_defines.svh -----
// Assertion macros used by the touch sequencer top level
`ifndef TOUCH_ADC_READ_SEQUENCER_DEFINES_SVH
`define TOUCH_ADC_READ_SEQUENCER_DEFINES_SVH

// Check a condition in the same cycle as its trigger
`define TARS_ASSERT_NOW(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

// Check a condition in the cycle after its trigger
`define TARS_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

// ----- rtl/tars_pkg.sv -----
// Shared types and constants for the touch converter read sequencer
`timescale 1ns / 1ps
package tars_pkg;

  // Command codes on the input channel
  typedef enum logic [1:0] {
    OP_TOUCH  = 2'd0,
    OP_SINGLE = 2'd1,
    OP_RESP   = 2'd2
  } op_t;

  // Result kinds on the output channel
  typedef enum logic [1:0] {
    KIND_CTRL   = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_CHAN   = 2'd2
  } kind_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_THRESHOLD  = 2'd0,
    REG_RESOLUTION = 2'd1,
    REG_POWER      = 2'd2,
    REG_TOUCH_REF  = 2'd3
  } reg_idx_t;

  // Sequence phase
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_Z1     = 3'd1,
    PH_Z2     = 3'd2,
    PH_X      = 3'd3,
    PH_Y      = 3'd4,
    PH_SINGLE = 3'd5
  } phase_t;

  // Converter channel codes of the touch channels
  localparam logic [2:0] CH_Y  = 3'd1;
  localparam logic [2:0] CH_Z1 = 3'd3;
  localparam logic [2:0] CH_Z2 = 3'd4;
  localparam logic [2:0] CH_X  = 3'd5;

  localparam logic [11:0] FULL_SCALE = 12'd4095;

  typedef struct packed {
    logic [12:0] press_min;
    logic        resolution_mode;
    logic [1:0]  pd_bits;
    logic        touch_se;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  channel_select;
    logic [15:0] response_word;
  } in_item_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [7:0]  control_out;
    logic        select_active;
    logic        touched;
    logic [11:0] x_pos;
    logic [11:0] y_pos;
    logic [11:0] channel_value;
  } result_t;

  // Status from the step logic to the top level
  typedef struct packed {
    logic    has_result;
    phase_t  phase;
  } step_stat_t;

endpackage

// ----- rtl/tars_if.sv -----
// Channel interfaces: command, result and configuration write
`timescale 1ns / 1ps
interface tars_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [2:0]  channel_select;
  logic [15:0] response_word;
  modport source (output valid, opcode, channel_select, response_word, input ready);
  modport sink (input valid, opcode, channel_select, response_word, output ready);
endinterface

interface tars_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  control_out;
  logic        select_active;
  logic        touched;
  logic [11:0] x_pos;
  logic [11:0] y_pos;
  logic [11:0] channel_value;
  modport source (output valid, result_kind, control_out, select_active, touched,
                  x_pos, y_pos, channel_value, input ready);
  modport sink (input valid, result_kind, control_out, select_active, touched,
                x_pos, y_pos, channel_value, output ready);
endinterface

interface tars_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [12:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/tars_cfg_regs.sv -----
// Configuration register file written through the config channel
`timescale 1ns / 1ps
module tars_cfg_regs
  import tars_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  tars_cfg_if.sink   cfg,
  output cfg_t       regs
);

  // Writes always complete in one beat
  assign cfg.ready = 1'b1;

  // Decode the index and load the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid) begin
      unique case (reg_idx_t'(cfg.index))
        REG_THRESHOLD:  regs.press_min       <= cfg.data;
        REG_RESOLUTION: regs.resolution_mode <= cfg.data[0];
        REG_POWER:      regs.pd_bits         <= cfg.data[1:0];
        REG_TOUCH_REF:  regs.touch_se        <= cfg.data[0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/tars_step.sv -----
// Phase sequencer: decodes one registered beat into a result and a state update
`timescale 1ns / 1ps
module tars_step
  import tars_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       regs,
  input  logic       item_valid,
  input  in_item_t   item,
  input  logic       advance,
  output step_stat_t stat,
  output result_t    result
);

  phase_t      phase;
  phase_t      phase_next;
  logic [11:0] z1_hold;
  logic [11:0] x_hold;
  logic [11:0] conv;
  logic [12:0] pressure;
  logic        is_touch_ch;
  logic        below;
  op_t         op;

  function automatic logic [7:0] ctrl_byte(input logic [2:0] ch, input logic se,
                                           input cfg_t c);
    ctrl_byte = {1'b1, ch, c.resolution_mode, se, c.pd_bits};
  endfunction

  assign op = op_t'(item.opcode);

  // Decode the response word, top bit masked
  always_comb begin
    if (regs.resolution_mode) begin
      conv = {item.response_word[14:7], 4'b0000};
    end else begin
      conv = item.response_word[14:3];
    end
  end

  // Pressure = 4095 - Z2 + Z1, never negative in 13 bits
  assign pressure = 13'(FULL_SCALE - conv) + {1'b0, z1_hold};
  assign below    = pressure < regs.press_min;

  assign is_touch_ch = (item.channel_select == CH_X) || (item.channel_select == CH_Y) ||
                       (item.channel_select == CH_Z1) || (item.channel_select == CH_Z2);

  // Next phase
  always_comb begin
    phase_next = phase;
    if (item_valid) begin
      unique case (op)
        OP_TOUCH:  phase_next = PH_Z1;
        OP_SINGLE: phase_next = PH_SINGLE;
        OP_RESP: begin
          unique case (phase)
            PH_Z1:   phase_next = PH_Z2;
            PH_Z2:   phase_next = below ? PH_IDLE : PH_X;
            PH_X:    phase_next = PH_Y;
            default: phase_next = PH_IDLE;
          endcase
        end
        default: phase_next = phase;
      endcase
    end
  end

  // Result for this beat
  always_comb begin
    result          = '0;
    result.result_kind = KIND_CTRL;
    stat.has_result = 1'b0;
    stat.phase      = phase;
    if (item_valid) begin
      unique case (op)
        OP_TOUCH: begin
          stat.has_result      = 1'b1;
          result.control_out   = ctrl_byte(CH_Z1, regs.touch_se, regs);
          result.select_active = 1'b1;
        end
        OP_SINGLE: begin
          stat.has_result      = 1'b1;
          result.control_out   = ctrl_byte(item.channel_select,
                                           is_touch_ch ? regs.touch_se : 1'b1, regs);
          result.select_active = 1'b1;
        end
        OP_RESP: begin
          unique case (phase)
            PH_Z1: begin
              stat.has_result      = 1'b1;
              result.control_out   = ctrl_byte(CH_Z2, regs.touch_se, regs);
              result.select_active = 1'b1;
            end
            PH_Z2: begin
              stat.has_result = 1'b1;
              if (below) begin
                result.result_kind = KIND_SAMPLE;
              end else begin
                result.control_out   = ctrl_byte(CH_X, regs.touch_se, regs);
                result.select_active = 1'b1;
              end
            end
            PH_X: begin
              stat.has_result      = 1'b1;
              result.control_out   = ctrl_byte(CH_Y, regs.touch_se, regs);
              result.select_active = 1'b1;
            end
            PH_Y: begin
              stat.has_result    = 1'b1;
              result.result_kind = KIND_SAMPLE;
              result.touched     = 1'b1;
              result.x_pos       = x_hold;
              result.y_pos       = conv;
            end
            PH_SINGLE: begin
              stat.has_result      = 1'b1;
              result.result_kind   = KIND_CHAN;
              result.channel_value = conv;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Advance the phase and capture held conversions when the beat retires
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      z1_hold <= '0;
      x_hold  <= '0;
    end else if (advance) begin
      phase <= phase_next;
      if (op == OP_RESP && phase == PH_Z1) begin
        z1_hold <= conv;
      end
      if (op == OP_RESP && phase == PH_X) begin
        x_hold <= conv;
      end
    end
  end

endmodule

// ----- rtl/tars_out_reg.sv -----
// Result register driving the output channel
`timescale 1ns / 1ps
module tars_out_reg
  import tars_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  result_t    result,
  output logic       free,
  tars_res_if.source res
);

  result_t held;
  logic    valid;

  // Slot can take a new beat when empty or being drained this cycle
  assign free = !valid || res.ready;

  // Hold valid until the sink takes the beat
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (res.ready) begin
      valid <= 1'b0;
    end
  end

  // Load the payload
  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign res.valid         = valid;
  assign res.result_kind   = held.result_kind;
  assign res.control_out   = held.control_out;
  assign res.select_active = held.select_active;
  assign res.touched       = held.touched;
  assign res.x_pos         = held.x_pos;
  assign res.y_pos         = held.y_pos;
  assign res.channel_value = held.channel_value;

endmodule

// ----- rtl/touch_adc_read_sequencer.sv -----
// Top level of the touch converter read sequencer
`timescale 1ns / 1ps
`include "touch_adc_read_sequencer_defines.svh"
// Sequences a resistive-touch converter read. A touch-read command yields the
// Z1 control byte; each conversion response then yields the next control byte
// (Z2, X, Y) or, at the end, a touch sample; a low pressure after Z2 ends the
// read at once with an untouched sample. A single-channel command yields one
// control byte and its response the channel value. The block accepts a beat in
// every cycle; a command beat is captured in the input register, then the phase
// logic loads its result into the result register, which presents the result
// beat.
// Only a stalled result register holds off new beats. Configuration writes
// complete in one beat and must be made while no read is in flight.
module touch_adc_read_sequencer
  import tars_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  tars_cmd_if.sink   cmd,
  tars_res_if.source res,
  tars_cfg_if.sink   cfg
);

  cfg_t       regs;
  in_item_t   item;
  logic       item_valid;
  logic       advance;
  logic       out_free;
  step_stat_t stat;
  result_t    result;
  logic       seq_end;
  logic       ctrl_beat;
  logic       ctrl_ok;
  logic       other_beat;
  logic       pos_clear;

  tars_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  tars_step u_step (
    .clk        (clk),
    .rst        (rst),
    .regs       (regs),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance),
    .stat       (stat),
    .result     (result)
  );

  tars_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (advance && stat.has_result),
    .result (result),
    .free   (out_free),
    .res    (res)
  );

  // Retire the held beat unless its result has nowhere to go
  assign advance   = item_valid && (!stat.has_result || out_free);
  assign cmd.ready = !item_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (cmd.ready) begin
      item_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      item <= '{opcode: cmd.opcode, channel_select: cmd.channel_select,
                response_word: cmd.response_word};
    end
  end

  // Terms for the checks below
  assign seq_end    = advance && stat.has_result && result.result_kind != KIND_CTRL;
  assign ctrl_beat  = res.valid && res.result_kind == KIND_CTRL;
  assign ctrl_ok    = res.select_active && res.control_out[7];
  assign other_beat = res.valid && res.result_kind != KIND_SAMPLE;
  assign pos_clear  = res.x_pos == 12'd0 && res.y_pos == 12'd0 && !res.touched;

  `TARS_ASSERT_NOW(a_stall_needs_item, !cmd.ready, item_valid, "input stalled while empty")
  `TARS_ASSERT_NEXT(a_end_goes_idle, seq_end, stat.phase == PH_IDLE, "read did not end")
  `TARS_ASSERT_NOW(a_ctrl_keeps_select, ctrl_beat, ctrl_ok, "control beat without start bit")
  `TARS_ASSERT_NOW(a_non_sample_zero, other_beat, pos_clear, "position on a non-sample beat")

endmodule
